[rtl/lsws_pkg.sv]
// Package for the LIFO stack with search: sizes, command and status codes,
// and the command/status structs between controller and datapath.
// Depends on nothing; used by every module of the block.
package lsws_pkg;

  // Built depth of the stack and the widths that follow from it.
  localparam int unsigned DEPTH   = 256;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;

  // Capacity register: fixed 9-bit field, resets to the full built depth.
  localparam int unsigned CAP_W     = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // Command codes carried by each input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic push;        // write the input word on top, count up
    logic pop;         // count down
    logic rd_top;      // read the top entry
    logic clear;       // drop every entry
    logic srch_start;  // latch the key and read the top entry
    logic srch_step;   // move the scan one entry down
    logic res_zero;    // result data and position zero
    logic res_data;    // result data from the memory read
    logic res_pos;     // result position from the scan index
  } lsws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic chk_zero;
  } lsws_stat_t;

endpackage

[rtl/lsws_ctrl.sv]
// Controller of the LIFO stack with search: accepts commands and sequences
// reads and the top-down scan. Depends on lsws_pkg.
module lsws_ctrl
  import lsws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  lsws_stat_t        stat_i,
  output lsws_cmd_t         dp_cmd_o,
  output logic              busy_o,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_e;

  state_e    state_q, state_d;
  logic      done_q, done_d;
  status_e   status_q, status_d;
  lsws_cmd_t cmd;

  // Next state, result status and datapath commands.
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    status_d = status_q;
    cmd      = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_PUSH: begin
              cmd.res_zero = 1'b1;
              done_d       = 1'b1;
              if (stat_i.full) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                cmd.push = 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (stat_i.empty) begin
                cmd.res_zero = 1'b1;
                status_d     = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                cmd.rd_top = 1'b1;
                cmd.pop    = (cmd_i == CMD_POP);
                state_d    = S_READ;
              end
            end
            CMD_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.res_zero = 1'b1;
              status_d     = ST_OK;
              done_d       = 1'b1;
            end
            CMD_SEARCH: begin
              if (stat_i.empty) begin
                cmd.res_zero = 1'b1;
                status_d     = ST_NOTFOUND;
                done_d       = 1'b1;
              end else begin
                cmd.srch_start = 1'b1;
                state_d        = S_SCAN;
              end
            end
            default: begin
              // Undefined codes leave the stack alone and report success.
              cmd.res_zero = 1'b1;
              status_d     = ST_OK;
              done_d       = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.res_data = 1'b1;
        status_d     = ST_OK;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd.res_pos = 1'b1;
          status_d    = ST_OK;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.chk_zero) begin
          cmd.res_zero = 1'b1;
          status_d     = ST_NOTFOUND;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result strobe and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign dp_cmd_o = cmd;
  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

[rtl/lsws_dp.sv]
// Datapath of the LIFO stack with search: entry memory, count, capacity,
// scan index and result registers. Depends on lsws_pkg.
module lsws_dp
  import lsws_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  lsws_cmd_t                cmd_i,
  output lsws_stat_t               stat_o,
  output logic signed [WORD_W-1:0] data_o,
  output logic [ADDR_W-1:0]        position_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_full_o,
  output logic                     is_empty_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] key_q;
  logic [CNT_W-1:0]  count_q;
  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-1:0] chk_q;
  logic [WORD_W-1:0] data_q;
  logic [ADDR_W-1:0] pos_q;

  logic [CNT_W-1:0]  count_m1;
  logic [ADDR_W-1:0] chk_m1;
  logic [ADDR_W-1:0] raddr;
  logic [CNT_W-1:0]  eff_cap;
  logic              full;

  // Effective capacity saturates at the built depth.
  assign eff_cap  = (cap_q > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
  assign full     = (count_q >= eff_cap);
  assign count_m1 = count_q - CNT_W'(1);
  assign chk_m1   = chk_q - ADDR_W'(1);
  assign raddr    = cmd_i.srch_step ? chk_m1 : count_m1[ADDR_W-1:0];

  // Entry memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[ADDR_W-1:0]] <= value_i;
    end
    if (cmd_i.rd_top || cmd_i.srch_start || cmd_i.srch_step) begin
      rdata_q <= mem[raddr];
    end
  end

  // Count and capacity registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.push) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_m1;
      end
    end
  end

  // Search key and scan index; the index names the entry now in rdata_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_start) begin
      key_q <= value_i;
      chk_q <= count_m1[ADDR_W-1:0];
    end else if (cmd_i.srch_step) begin
      chk_q <= chk_m1;
    end
  end

  // Result word registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      data_q <= '0;
      pos_q  <= '0;
    end else if (cmd_i.res_data) begin
      data_q <= rdata_q;
      pos_q  <= '0;
    end else if (cmd_i.res_pos) begin
      data_q <= '0;
      pos_q  <= chk_q;
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = full;
  assign stat_o.match    = (rdata_q == key_q);
  assign stat_o.chk_zero = (chk_q == '0);

  assign data_o     = data_q;
  assign position_o = pos_q;
  assign count_o    = count_q;
  assign is_full_o  = full;
  assign is_empty_o = (count_q == '0);

`ifndef ASSERT_OFF
  // The count never exceeds the built depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("stack count above depth");

  // A push is only issued below the effective capacity.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q < eff_cap))
    else $error("push issued on a full stack");

  // A pop is only issued on a non-empty stack and lowers the count by one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0) ##1 (count_q == $past(count_m1)))
    else $error("pop on empty stack or count not lowered");
`endif

endmodule

[rtl/lifo_stack_with_search.sv]
// Top level of the LIFO stack with search: joins controller and datapath.
// Depends on lsws_pkg, lsws_ctrl and lsws_dp.
//
// A command word is taken when start_i is high and busy_o is low, and its
// result appears for exactly one cycle with done_o high; the receiver
// cannot hold it off. Push, clear, refused commands and undefined codes
// give their result in the cycle after acceptance and keep busy_o low, so
// one such command can be taken every cycle. Pop and peek read the entry
// memory, which has a registered read port: busy_o is high for one cycle
// and the result is registered from the read port register. Search walks
// the single-read-port memory from the top down, one entry per cycle, with
// busy_o high until an entry matches or all held entries are examined.
// count_o, is_full_o and is_empty_o follow the stored count and are valid
// with every result. Capacity is written with cfg_we_i; the user must do
// so only while the block is idle, as the block does not enforce it.
// Values above the built depth act as the depth and zero refuses every
// push.
module lifo_stack_with_search
  import lsws_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [WORD_W-1:0] data_o,
  output logic [ADDR_W-1:0]        position_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_full_o,
  output logic                     is_empty_o
);

  lsws_cmd_t  dp_cmd;
  lsws_stat_t dp_stat;

  // Command sequencing.
  lsws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .status_o (status_o)
  );

  // Storage, count and result words.
  lsws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .data_o      (data_o),
    .position_o  (position_o),
    .count_o     (count_o),
    .is_full_o   (is_full_o),
    .is_empty_o  (is_empty_o)
  );

endmodule
